### hdl/fjop_pkg.sv
// Shared codes, types and helper functions for the flat JSON object parser.
package fjop_pkg;

  // Parse phases
  localparam logic [3:0] PH_OPEN        = 4'd0;
  localparam logic [3:0] PH_FIRST       = 4'd1;
  localparam logic [3:0] PH_STRING      = 4'd2;
  localparam logic [3:0] PH_ESCAPE      = 4'd3;
  localparam logic [3:0] PH_HEX         = 4'd4;
  localparam logic [3:0] PH_COLON       = 4'd5;
  localparam logic [3:0] PH_VALUE_QUOTE = 4'd6;
  localparam logic [3:0] PH_SEPARATOR   = 4'd7;
  localparam logic [3:0] PH_KEY_QUOTE   = 4'd8;
  localparam logic [3:0] PH_DONE        = 4'd9;

  // Result kinds
  localparam logic [2:0] KIND_KEY_CHAR = 3'd0;
  localparam logic [2:0] KIND_VAL_CHAR = 3'd1;
  localparam logic [2:0] KIND_KEY_END  = 3'd2;
  localparam logic [2:0] KIND_VAL_END  = 3'd3;
  localparam logic [2:0] KIND_ACCEPT   = 3'd4;
  localparam logic [2:0] KIND_REJECT   = 3'd5;

  // Input command codes
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [15:0] HEX_ASCII_MAX = 16'h007F;
  localparam logic [7:0]  CHAR_SUBST    = 8'h3F;  // '?'

  typedef struct packed {
    logic [3:0]  phase;
    logic        is_key;
    logic [15:0] hex_acc;
    logic [1:0]  hex_cnt;
    logic        err;
  } parse_state_t;

  typedef struct packed {
    logic       emit;
    logic [2:0] kind;
    logic [7:0] chr;
  } parse_result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:   PH_OPEN,
    is_key:  1'b0,
    hex_acc: 16'h0000,
    hex_cnt: 2'd0,
    err:     1'b0
  };

  function automatic logic is_blank(input logic [7:0] b);
    return b inside {8'h20, [8'h09:8'h0D]};
  endfunction

  // Bit 4 flags a valid hex digit, bits 3:0 give its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, b[3:0]};
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, 4'(b[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

### hdl/flat_json_object_parser_top.sv
// Top level of the streaming flat JSON object parser.
//
// Usage:
//   Input channel (in_valid/in_ready): one transaction per byte; in_cmd = 0
//   carries a data byte in in_byte, in_cmd = 1 marks end of object.
//   Result channel (out_valid/out_ready): zero or one transaction per input
//   transaction - key/value characters, key/value end markers, and one
//   accept or reject per end-of-object.
// Timing:
//   A byte is captured in the input register, then the phase logic writes
//   its result into the output register. Throughput is one byte per cycle
//   unless out_ready stalls the output; the only loop is the parse state
//   register updated by one short transition step.
// Reset (rst_n low, synchronous): both registers empty, parser back to
//   waiting for the opening brace, error flag clear.
// Stall: while out_valid is held off by out_ready, the input register
//   still takes one byte; further bytes wait with in_ready low. No
//   transaction is dropped or repeated.
module flat_json_object_parser_top
  import fjop_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_char
);

  // input register
  logic       s1_valid_r;
  logic       s1_cmd_r;
  logic [7:0] s1_byte_r;

  // parse state and output register
  parse_state_t  state_r;
  parse_state_t  state_nxt;
  parse_result_t res;
  logic          out_valid_r;
  logic [2:0]    out_kind_r;
  logic [7:0]    out_char_r;

  logic advance;

  // The held byte moves on once the output register is free or draining.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  fjop_step u_step (
    .cur     (state_r),
    .cmd     (s1_cmd_r),
    .in_byte (s1_byte_r),
    .nxt     (state_nxt),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r  <= in_cmd;
      s1_byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      state_r     <= state_nxt;
      out_valid_r <= res.emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_kind_r <= res.kind;
      out_char_r <= res.chr;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_char  = out_char_r;

endmodule

### hdl/fjop_step.sv
// Per-byte transition of the parser: next state and optional result.
module fjop_step
  import fjop_pkg::*;
(
  input  parse_state_t  cur,
  input  logic          cmd,
  input  logic [7:0]    in_byte,
  output parse_state_t  nxt,
  output parse_result_t res
);

  logic [4:0]  hd;
  logic [15:0] acc_shift;

  assign hd        = hex_digit(in_byte);
  assign acc_shift = {cur.hex_acc[11:0], hd[3:0]};

  always_comb begin
    nxt      = cur;
    res.emit = 1'b0;
    res.kind = KIND_KEY_CHAR;
    res.chr  = 8'h00;

    if (cmd == CMD_END) begin
      nxt      = STATE_RESET;
      res.emit = 1'b1;
      res.kind = (!cur.err && cur.phase == PH_DONE) ? KIND_ACCEPT : KIND_REJECT;
    end else if (!cur.err) begin
      case (cur.phase)
        PH_OPEN: begin
          if (in_byte == 8'h7B) begin
            nxt.phase = PH_FIRST;
          end else if (!is_blank(in_byte)) begin
            nxt.err = 1'b1;
          end
        end
        PH_FIRST, PH_KEY_QUOTE: begin
          if (in_byte == 8'h22) begin
            nxt.is_key = 1'b1;
            nxt.phase  = PH_STRING;
          end else if (in_byte == 8'h7D && cur.phase == PH_FIRST) begin
            nxt.phase = PH_DONE;
          end else if (!is_blank(in_byte)) begin
            nxt.err = 1'b1;
          end
        end
        PH_STRING: begin
          if (in_byte == 8'h22) begin
            nxt.phase = cur.is_key ? PH_COLON : PH_SEPARATOR;
            res.emit  = 1'b1;
            res.kind  = cur.is_key ? KIND_KEY_END : KIND_VAL_END;
          end else if (in_byte == 8'h5C) begin
            nxt.phase = PH_ESCAPE;
          end else begin
            res.emit = 1'b1;
            res.kind = cur.is_key ? KIND_KEY_CHAR : KIND_VAL_CHAR;
            res.chr  = in_byte;
          end
        end
        PH_ESCAPE: begin
          nxt.phase = PH_STRING;
          res.kind  = cur.is_key ? KIND_KEY_CHAR : KIND_VAL_CHAR;
          res.emit  = 1'b1;
          case (in_byte)
            8'h5C, 8'h22, 8'h2F: res.chr = in_byte;
            8'h62:               res.chr = 8'h08;  // b
            8'h66:               res.chr = 8'h0C;  // f
            8'h6E:               res.chr = 8'h0A;  // n
            8'h72:               res.chr = 8'h0D;  // r
            8'h74:               res.chr = 8'h09;  // t
            8'h75: begin                           // u
              res.emit    = 1'b0;
              nxt.hex_acc = 16'h0000;
              nxt.hex_cnt = 2'd0;
              nxt.phase   = PH_HEX;
            end
            default: begin
              res.emit = 1'b0;
              nxt.err  = 1'b1;
            end
          endcase
        end
        PH_HEX: begin
          if (!hd[4]) begin
            nxt.err = 1'b1;
          end else begin
            nxt.hex_acc = acc_shift;
            if (cur.hex_cnt != 2'd3) begin
              nxt.hex_cnt = cur.hex_cnt + 2'd1;
            end else begin
              nxt.hex_cnt = 2'd0;
              nxt.phase   = PH_STRING;
              res.emit    = 1'b1;
              res.kind    = cur.is_key ? KIND_KEY_CHAR : KIND_VAL_CHAR;
              res.chr     = (acc_shift <= HEX_ASCII_MAX) ? acc_shift[7:0] : CHAR_SUBST;
            end
          end
        end
        PH_COLON: begin
          if (in_byte == 8'h3A) begin
            nxt.phase = PH_VALUE_QUOTE;
          end else if (!is_blank(in_byte)) begin
            nxt.err = 1'b1;
          end
        end
        PH_VALUE_QUOTE: begin
          if (in_byte == 8'h22) begin
            nxt.is_key = 1'b0;
            nxt.phase  = PH_STRING;
          end else if (!is_blank(in_byte)) begin
            nxt.err = 1'b1;
          end
        end
        PH_SEPARATOR: begin
          if (in_byte == 8'h7D) begin
            nxt.phase = PH_DONE;
          end else if (in_byte == 8'h2C) begin
            nxt.phase = PH_KEY_QUOTE;
          end else if (!is_blank(in_byte)) begin
            nxt.err = 1'b1;
          end
        end
        PH_DONE: begin
          if (!is_blank(in_byte)) begin
            nxt.err = 1'b1;
          end
        end
        default: begin
          nxt.err = 1'b1;
        end
      endcase
    end
  end

endmodule

### hdl/fjop_checker.sv
// Port-level checker for the parser, bound to the top level.
module fjop_checker
  import fjop_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic [7:0] out_char
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_char))
    else $error("result changed while stalled");

  // Markers and verdicts carry a zero character
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_KEY_END || out_kind == KIND_VAL_END ||
                  out_kind == KIND_ACCEPT || out_kind == KIND_REJECT) |-> out_char == 8'h00)
    else $error("non-character result with non-zero char");

  // Only defined kinds appear
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= KIND_REJECT)
    else $error("undefined result kind");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input side is never blocked once the pipeline has drained
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && !out_valid |=> in_ready)
    else $error("input blocked with empty pipeline");

endmodule

bind flat_json_object_parser_top fjop_checker u_fjop_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_kind  (out_kind),
  .out_char  (out_char)
);
